### sv/assert_macros.svh
// assertion macros shared by the allocator rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the following clock
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/ffha_pkg.sv
// shared types and constants for the first-fit heap allocator
// no dependencies
package ffha_pkg;
    localparam int unsigned FIELD_W = 15;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_ZALLOC  = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_RESIZE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_SPACE   = 3'd2,
        ST_FULL    = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DISPATCH,
        S_FIND_RD,
        S_FIND_CHK,
        S_FIT_RD,
        S_FIT_CHK,
        S_APPEND,
        S_REL_RD,
        S_REL_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [FIELD_W-1:0] address;
        logic [FIELD_W-1:0] request_size;
        logic [FIELD_W-1:0] element_count;
        logic [1:0]         action;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] result_address;
        logic [2:0]         status;
        logic [FIELD_W-1:0] move_from;
        logic [FIELD_W-1:0] move_length;
        logic [FIELD_W-1:0] clear_length;
    } t_rsp;
endpackage

### sv/ffha_if.sv
// valid/ready channel interfaces for requests, responses and configuration
// depends on ffha_pkg
interface ffha_req_if;
    logic            valid;
    logic            ready;
    ffha_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ffha_rsp_if;
    logic            valid;
    logic            ready;
    ffha_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ffha_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ffha_pkg::FIELD_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/ffha_mul.sv
// shift-and-add multiplier, one bit of the multiplier per cycle
// depends on ffha_pkg
module ffha_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [ffha_pkg::FIELD_W-1:0]         i_a,
    input  logic [ffha_pkg::FIELD_W-1:0]         i_b,
    output logic                                 o_done,
    output logic [2*ffha_pkg::FIELD_W-1:0]       o_prod
);
    import ffha_pkg::*;

    localparam int unsigned CNT_W = $clog2(FIELD_W + 1);

    logic [2*FIELD_W-1:0] r_acc, n_acc;
    logic [2*FIELD_W-1:0] r_mcand, n_mcand;
    logic [FIELD_W-1:0]   r_mplier, n_mplier;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_busy, n_busy;

    // one add per step
    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        if (i_start) begin
            n_acc    = '0;
            n_mcand  = {{FIELD_W{1'b0}}, i_a};
            n_mplier = i_b;
            n_cnt    = CNT_W'(FIELD_W);
            n_busy   = 1'b1;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_done = r_busy && (r_cnt == CNT_W'(1));
    assign o_prod = n_acc;
endmodule

### sv/first_fit_heap_allocator.sv
// The block takes no new request until the response to the last one has been
// accepted. Release and resize walk the block table entry by entry (read, then
// compare) to find the address; allocate walks it in the same way, with the
// same read and compare steps, for the first free block that fits, then appends
// at the top. A zeroed allocate first waits for the multiplier, and the response
// is held until ready. The table is a single-port memory with registered read
// data and needs no clearing after reset.
// top level of the first-fit heap allocator; depends on ffha_pkg, ffha_if,
// ffha_mul and assert_macros.svh
module first_fit_heap_allocator #(
    parameter int unsigned HEAP_BYTES   = 16384,
    parameter int unsigned MAX_BLOCKS   = 1024,
    parameter int unsigned HEADER_BYTES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ffha_req_if.sink  i_req,
    ffha_rsp_if.source o_rsp,
    ffha_cfg_if.sink  i_cfg
);
    import ffha_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned W     = FIELD_W;
    localparam int unsigned XW    = 2 * FIELD_W + 1;
    localparam logic [XW-1:0] HDR = XW'(HEADER_BYTES);
    localparam logic [XW-1:0] HEAP_MAX = XW'(HEAP_BYTES);

    // block table memory: start, size, free mark
    logic [2*W:0]  r_mem [MAX_BLOCKS];
    logic [2*W:0]  r_rd;
    logic          mem_we;
    logic [IDX_W-1:0] mem_addr;
    logic [2*W:0]  mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rd <= r_mem[mem_addr];
    end

    logic [W-1:0] rd_start, rd_bytes;
    logic         rd_free;
    assign rd_start = r_rd[2*W:W+1];
    assign rd_bytes = r_rd[W:1];
    assign rd_free  = r_rd[0];

    t_state       r_state, n_state;
    t_req         r_req, n_req;
    t_rsp         r_rsp, n_rsp;
    logic [W-1:0] r_limit, n_limit;
    logic [CNT_W-1:0] r_count, n_count;
    logic [W:0]   r_top, n_top;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_found, n_found;
    logic [W-1:0] r_old_bytes, n_old_bytes;
    logic [W-1:0] r_old_start, n_old_start;
    logic [XW-1:0] r_size, n_size;
    logic         r_move, n_move;

    logic             mul_start, mul_done;
    logic [2*W-1:0]   mul_prod;

    // operands are taken straight from the accepted transaction
    ffha_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (i_req.data.element_count),
        .i_b     (i_req.data.request_size),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    logic [XW-1:0] lim;
    logic [XW-1:0] need;
    assign lim  = (XW'(r_limit) > HEAP_MAX) ? HEAP_MAX : XW'(r_limit);
    assign need = XW'(r_top) + HDR + r_size;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_DONE);
    assign o_rsp.data  = r_rsp;
    assign i_cfg.ready = 1'b1;

    // sequencer: next state, table access and response
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_rsp       = r_rsp;
        n_limit     = r_limit;
        n_count     = r_count;
        n_top       = r_top;
        n_idx       = r_idx;
        n_found     = r_found;
        n_old_bytes = r_old_bytes;
        n_old_start = r_old_start;
        n_size      = r_size;
        n_move      = r_move;
        mul_start   = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = r_idx[IDX_W-1:0];
        mem_wd      = r_rd;
        if (i_cfg.valid) begin
            n_limit = i_cfg.data;
        end
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.data;
                    n_rsp   = '0;
                    n_move  = 1'b0;
                    n_idx   = '0;
                    n_size  = XW'(i_req.data.request_size);
                    if (t_action'(i_req.data.action) == ACT_ZALLOC &&
                        i_req.data.request_size != '0 &&
                        i_req.data.element_count != '0) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_DISPATCH;
                    end
                end
            end
            S_MUL: begin
                mul_start = 1'b0;
                if (mul_done) begin
                    n_size  = XW'(mul_prod);
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_idx = '0;
                case (t_action'(r_req.action))
                    ACT_ALLOC: begin
                        if (r_size == '0) begin
                            n_rsp.status = ST_NULL;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_FIT_RD;
                        end
                    end
                    ACT_ZALLOC: begin
                        if (r_req.request_size == '0 || r_req.element_count == '0) begin
                            n_rsp.status = ST_NULL;
                            n_state = S_DONE;
                        end else if (r_size > lim) begin
                            n_rsp.status = ST_SPACE;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_FIT_RD;
                        end
                    end
                    ACT_RELEASE: begin
                        if (r_req.address == '0) begin
                            n_rsp.status = ST_NULL;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_FIND_RD;
                        end
                    end
                    default: begin
                        if (r_req.address == '0 || r_req.request_size == '0) begin
                            if (r_size == '0) begin
                                n_rsp.status = ST_NULL;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_FIT_RD;
                            end
                        end else begin
                            n_state = S_FIND_RD;
                        end
                    end
                endcase
            end
            // lookup of the address in the table
            S_FIND_RD: begin
                if (r_idx >= r_count) begin
                    n_rsp.status = ST_UNKNOWN;
                    n_state = S_DONE;
                end else begin
                    n_state = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                if (XW'(rd_start) + HDR == XW'(r_req.address)) begin
                    n_found     = r_idx;
                    n_old_bytes = rd_bytes;
                    n_old_start = rd_start;
                    if (t_action'(r_req.action) == ACT_RELEASE) begin
                        n_state = S_REL_CHK;
                    end else if (XW'(rd_bytes) >= r_size) begin
                        n_rsp.result_address = r_req.address;
                        n_state = S_DONE;
                    end else begin
                        n_move  = 1'b1;
                        n_idx   = '0;
                        n_state = S_FIT_RD;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FIND_RD;
                end
            end
            // first-fit search
            S_FIT_RD: begin
                if (r_idx >= r_count) begin
                    n_state = S_APPEND;
                end else begin
                    n_state = S_FIT_CHK;
                end
            end
            S_FIT_CHK: begin
                if (rd_free && XW'(rd_bytes) >= r_size) begin
                    mem_we = 1'b1;
                    mem_wd = {rd_start, rd_bytes, 1'b0};
                    n_rsp.result_address = W'(XW'(rd_start) + HDR);
                    n_state = S_REL_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FIT_RD;
                end
            end
            S_APPEND: begin
                if (need > lim) begin
                    n_rsp.status = ST_SPACE;
                    n_state = S_DONE;
                end else if (r_count >= CNT_W'(MAX_BLOCKS)) begin
                    n_rsp.status = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    mem_we   = 1'b1;
                    mem_addr = r_count[IDX_W-1:0];
                    mem_wd   = {W'(r_top), W'(r_size), 1'b0};
                    n_count  = r_count + 1'b1;
                    n_rsp.result_address = W'(XW'(r_top) + HDR);
                    n_top    = (W+1)'(need);
                    n_state  = S_REL_RD;
                end
            end
            // allocation succeeded: finish zeroing or release old block
            S_REL_RD: begin
                if (t_action'(r_req.action) == ACT_ZALLOC) begin
                    n_rsp.clear_length = W'(r_size);
                end
                if (r_move) begin
                    n_rsp.move_from   = r_req.address;
                    n_rsp.move_length = r_old_bytes;
                    n_state = S_REL_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REL_CHK: begin
                if (XW'(r_old_start) + HDR + XW'(r_old_bytes) == XW'(r_top) &&
                    r_count != '0) begin
                    n_count = r_count - 1'b1;
                    n_top   = (W+1)'(r_old_start);
                end else begin
                    mem_we   = 1'b1;
                    mem_addr = r_found[IDX_W-1:0];
                    mem_wd   = {r_old_start, r_old_bytes, 1'b1};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE && i_req.valid &&
            t_action'(i_req.data.action) == ACT_ZALLOC) begin
            mul_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= W'(16384);
            r_count <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_limit <= n_limit;
            r_count <= n_count;
            r_top   <= n_top;
        end
        r_req       <= n_req;
        r_rsp       <= n_rsp;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_old_bytes <= n_old_bytes;
        r_old_start <= n_old_start;
        r_size      <= n_size;
        r_move      <= n_move;
    end

    // checks
    `ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_BLOCKS))
    `ASSERT_IMPL(a_top_empty, i_clk, i_rst_n, r_count == '0, r_top == '0)
    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready,
        o_rsp.valid && $stable(r_rsp))
    `ASSERT_IMPL(a_move_ok, i_clk, i_rst_n, o_rsp.valid && r_rsp.move_length != '0,
        r_rsp.status == ST_OK)
endmodule
